@@ rtl/core/lsc_pkg.sv @@
package lsc_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int PROBES        = 16;
  localparam int HALF          = PROBES / 2;
  localparam int IN_W          = 16;
  localparam int CNT_W         = 5;
  localparam int HCNT_W        = 4;
  localparam int HW_W          = 5;
  localparam int SUMI_W        = 8;
  localparam int SUM_W         = 7;
  localparam int MAG_W         = 6;
  localparam int NUM_W         = MAG_W + FRAC_BITS;
  localparam int RECIP_SHIFT   = NUM_W + 4;
  localparam int RECIP_W       = RECIP_SHIFT + 1;
  localparam int PROD_W        = NUM_W + RECIP_W;
  localparam int POS_W         = 13;
  localparam int POS_MAX       = 4095;
  localparam int POS_MIN_MAG   = 4096;
  localparam int OUT_DATA_W    = 24;
  localparam int WEIGHT_OFFSET = 7;

  localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
    RECIP_W'(0),
    RECIP_W'(((1 << RECIP_SHIFT) + 0) / 1),
    RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2),
    RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3),
    RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4),
    RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5),
    RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6),
    RECIP_W'(((1 << RECIP_SHIFT) + 6) / 7),
    RECIP_W'(((1 << RECIP_SHIFT) + 7) / 8),
    RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9),
    RECIP_W'(((1 << RECIP_SHIFT) + 9) / 10),
    RECIP_W'(((1 << RECIP_SHIFT) + 10) / 11),
    RECIP_W'(((1 << RECIP_SHIFT) + 11) / 12),
    RECIP_W'(((1 << RECIP_SHIFT) + 12) / 13),
    RECIP_W'(((1 << RECIP_SHIFT) + 13) / 14),
    RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15)
  };

  typedef struct packed {
    logic              vld;
    logic [HCNT_W-1:0] cnt_lo;
    logic [HCNT_W-1:0] cnt_hi;
    logic [HW_W-1:0]   wsum_lo;
    logic [HW_W-1:0]   wsum_hi;
  } half_t;

  typedef struct packed {
    logic                    vld;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } tally_t;

  typedef struct packed {
    logic               vld;
    logic               pos_ok;
    logic               neg;
    logic [CNT_W-1:0]   cnt;
    logic [NUM_W-1:0]   num;
    logic [RECIP_W-1:0] recip;
  } recip_t;

  typedef struct packed {
    logic              vld;
    logic              pos_ok;
    logic              neg;
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
  } prod_t;

endpackage

@@ rtl/core/lsc_count.sv @@
module lsc_count (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [lsc_pkg::IN_W-1:0] raw_bits,
  output lsc_pkg::tally_t        tally
);
  import lsc_pkg::*;

  half_t               half;
  half_t               half_next;
  tally_t              tally_next;
  logic [SUMI_W-1:0]   sum_i;
  logic [CNT_W-1:0]    cnt;
  logic [SUMI_W-1:0]   sum_full;

  always_comb begin
    half_next.vld     = in_vld;
    half_next.cnt_lo  = '0;
    half_next.cnt_hi  = '0;
    half_next.wsum_lo = '0;
    half_next.wsum_hi = '0;
    for (int j = 0; j < HALF; j++) begin
      half_next.cnt_lo  = half_next.cnt_lo + HCNT_W'(raw_bits[j]);
      half_next.cnt_hi  = half_next.cnt_hi + HCNT_W'(raw_bits[j + HALF]);
      half_next.wsum_lo = half_next.wsum_lo + (raw_bits[j] ? HW_W'(j) : '0);
      half_next.wsum_hi = half_next.wsum_hi + (raw_bits[j + HALF] ? HW_W'(j) : '0);
    end
  end

  always_comb begin
    cnt      = CNT_W'(half.cnt_lo) + CNT_W'(half.cnt_hi);
    sum_i    = SUMI_W'(half.wsum_lo) + SUMI_W'(half.wsum_hi)
             + SUMI_W'({half.cnt_hi, 3'b000});
    sum_full = sum_i - SUMI_W'(cnt) * SUMI_W'(WEIGHT_OFFSET);
    tally_next.vld = half.vld;
    tally_next.cnt = cnt;
    tally_next.sum = sum_full[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half.vld  <= 1'b0;
      tally.vld <= 1'b0;
    end else if (en) begin
      half  <= half_next;
      tally <= tally_next;
    end
  end

endmodule

@@ rtl/core/lsc_div.sv @@
module lsc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  lsc_pkg::tally_t tally,
  output lsc_pkg::prod_t  prod
);
  import lsc_pkg::*;

  recip_t             rcp;
  recip_t             rcp_next;
  prod_t              prod_next;
  logic [SUM_W-1:0]   abs_v;

  always_comb begin
    rcp_next.vld    = tally.vld;
    rcp_next.neg    = tally.sum[SUM_W-1];
    rcp_next.cnt    = tally.cnt;
    rcp_next.pos_ok = (tally.cnt != '0) && (tally.cnt != CNT_W'(PROBES));
    abs_v           = rcp_next.neg ? (~tally.sum + SUM_W'(1)) : tally.sum;
    rcp_next.num    = {abs_v[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    rcp_next.recip  = RECIP_TAB[tally.cnt[HCNT_W-1:0]];
  end

  always_comb begin
    prod_next.vld    = rcp.vld;
    prod_next.pos_ok = rcp.pos_ok;
    prod_next.neg    = rcp.neg;
    prod_next.cnt    = rcp.cnt;
    prod_next.prod   = PROD_W'(rcp.num) * PROD_W'(rcp.recip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcp.vld  <= 1'b0;
      prod.vld <= 1'b0;
    end else if (en) begin
      rcp  <= rcp_next;
      prod <= prod_next;
    end
  end

endmodule

@@ rtl/core/line_sensor_centroid_core.sv @@
// Inputs pass the half, tally, rcp, prod and output registers to m_tvalid.
// Throughput: one transaction per cycle while m_tready does not stall; the
// probe count, the reciprocal multiply and the saturation stage are all
// fully pipelined. Backpressure on m_tready holds every stage in place.
// Reset (rst, synchronous, active high) clears all stage valid bits.
module line_sensor_centroid_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lsc_pkg::IN_W-1:0]       s_tdata,  // [15:0] raw_bits
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lsc_pkg::OUT_DATA_W-1:0] m_tdata,  // [12:0] position_fixed,
                                                   // [17:13] probe_count
  output logic                           m_tuser   // [0] position_valid
);
  import lsc_pkg::*;

  logic              en;
  tally_t            tally;
  prod_t             prod;
  logic [31:0]       q_ext;
  logic [31:0]       lim;
  logic [31:0]       mag_sat;
  logic [POS_W-1:0]  mag_w;
  logic [POS_W-1:0]  pos;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  lsc_count u_count (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_tvalid),
    .raw_bits (s_tdata),
    .tally    (tally)
  );

  lsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tally (tally),
    .prod  (prod)
  );

  always_comb begin
    q_ext   = 32'(prod.prod >> RECIP_SHIFT);
    lim     = prod.neg ? 32'(POS_MIN_MAG) : 32'(POS_MAX);
    mag_sat = (q_ext > lim) ? lim : q_ext;
    mag_w   = mag_sat[POS_W-1:0];
    if (!prod.pos_ok) begin
      pos = '0;
    end else if (prod.neg) begin
      pos = ~mag_w + POS_W'(1);
    end else begin
      pos = mag_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= prod.vld;
      m_tdata  <= OUT_DATA_W'({prod.cnt, pos});
      m_tuser  <= prod.pos_ok;
    end
  end

endmodule
